// ----- sv/ezr_pkg.sv -----
// ----------------------------------------------------------------------------
// ezr_pkg: shared types, constants and tables for the euler zyx rotation unit
// cordic arctangent table in turns (2^32 per turn), fixed-point formats
// ----------------------------------------------------------------------------
package ezr_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int INT_FRAC   = 30;
    localparam int STEPS      = 31;
    localparam int OUT_W      = 16;
    localparam int CW         = 34;   // cordic x/y width
    localparam int ZW         = 33;   // cordic phase width
    localparam int QW         = 32;   // q1.30 value width
    localparam int SH         = INT_FRAC - FRAC_BITS;

    localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;

    typedef logic signed [QW-1:0] t_q;

    typedef struct packed {
        t_q sx, cx, sy, cy, sz, cz;
    } t_trig;

    function automatic logic signed [ZW-1:0] atan_turns(input logic [4:0] i);
        case (i)
            5'd0:  atan_turns = 33'sd536870912;
            5'd1:  atan_turns = 33'sd316933406;
            5'd2:  atan_turns = 33'sd167458907;
            5'd3:  atan_turns = 33'sd85004756;
            5'd4:  atan_turns = 33'sd42667331;
            5'd5:  atan_turns = 33'sd21354465;
            5'd6:  atan_turns = 33'sd10679838;
            5'd7:  atan_turns = 33'sd5340245;
            5'd8:  atan_turns = 33'sd2670163;
            5'd9:  atan_turns = 33'sd1335087;
            5'd10: atan_turns = 33'sd667544;
            5'd11: atan_turns = 33'sd333772;
            5'd12: atan_turns = 33'sd166886;
            5'd13: atan_turns = 33'sd83443;
            5'd14: atan_turns = 33'sd41722;
            5'd15: atan_turns = 33'sd20861;
            5'd16: atan_turns = 33'sd10430;
            5'd17: atan_turns = 33'sd5215;
            5'd18: atan_turns = 33'sd2608;
            5'd19: atan_turns = 33'sd1304;
            5'd20: atan_turns = 33'sd652;
            5'd21: atan_turns = 33'sd326;
            5'd22: atan_turns = 33'sd163;
            5'd23: atan_turns = 33'sd81;
            5'd24: atan_turns = 33'sd41;
            5'd25: atan_turns = 33'sd20;
            5'd26: atan_turns = 33'sd10;
            5'd27: atan_turns = 33'sd5;
            5'd28: atan_turns = 33'sd3;
            default: atan_turns = 33'sd1;
        endcase
    endfunction

    // q1.30 product rounded half up
    function automatic t_q qmul(input t_q a, input t_q b);
        logic signed [2*QW-1:0] p;
        p = (2*QW)'(a) * (2*QW)'(b) + (2*QW)'(64'sd1 <<< (INT_FRAC - 1));
        qmul = QW'(p >>> INT_FRAC);
    endfunction

    // round q1.30 to output format and saturate
    function automatic logic [OUT_W-1:0] to_out(input logic signed [QW+1:0] v);
        logic signed [QW+1:0] r;
        logic signed [QW+1:0] lim;
        lim = (QW+2)'(1) <<< FRAC_BITS;
        r = (v + ((QW+2)'(1) <<< (SH - 1))) >>> SH;
        if (r > lim)  r = lim;
        if (r < -lim) r = -lim;
        to_out = r[OUT_W-1:0];
    endfunction

endpackage

// ----- sv/ezr_cordic.sv -----
// ----------------------------------------------------------------------------
// ezr_cordic: pipelined rotation-mode cordic, one step per stage
// gives sine and cosine in q1.30 with half-turn folding
// ----------------------------------------------------------------------------
module ezr_cordic (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [ezr_pkg::ANGLE_BITS-1:0]  i_angle,
    output ezr_pkg::t_q                     o_sin,
    output ezr_pkg::t_q                     o_cos
);
    import ezr_pkg::*;

    logic signed [CW-1:0] r_x [STEPS+1];
    logic signed [CW-1:0] r_y [STEPS+1];
    logic signed [ZW-1:0] r_z [STEPS+1];
    logic                 r_f [STEPS+1];

    logic [31:0] phase;
    logic        flip;

    assign phase = {i_angle, {(32-ANGLE_BITS){1'b0}}};
    assign flip  = phase[31] ^ phase[30];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= INV_GAIN;
            r_y[0] <= '0;
            r_z[0] <= ZW'($signed({phase[31] ^ flip, phase[30:0]}));
            r_f[0] <= flip;
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_f[g+1] <= r_f[g];
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_turns(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_turns(5'(g));
                end
            end
        end
    end

    assign o_sin = QW'(r_f[STEPS] ? -r_y[STEPS] : r_y[STEPS]);
    assign o_cos = QW'(r_f[STEPS] ? -r_x[STEPS] : r_x[STEPS]);

endmodule

// ----- sv/euler_zyx_rotation_matrix_unit.sv -----
// ----------------------------------------------------------------------------
// euler_zyx_rotation_matrix_unit: rotation matrix R = Rz*Ry*Rx from angles
// three pipelined cordics, two product stages, rounding and saturation
// ----------------------------------------------------------------------------
// channel   dir  tdata fields (low bit first)
// s_axis    in   angle_x[15:0], angle_y[31:16], angle_z[47:32]
// m_axis    out  m00..m22, 16 bits each, row major
//
// one transfer per cycle sustained while the output is free or taken;
// stages: cordic, two multiply stages, one rounding stage, output register
// the whole pipeline advances together when the output is free or taken
// reset clears only the valid bits; a stall holds every stage
// ----------------------------------------------------------------------------
module euler_zyx_rotation_matrix_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // angle_x, angle_y, angle_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata    // m00 m01 m02 m10 m11 m12 m20 m21 m22
);
    import ezr_pkg::*;

    localparam int LAT = STEPS + 5;

    // valid shift line
    logic [LAT-1:0] r_v;
    logic           en;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_v[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[LAT-2:0], s_axis_tvalid};
        end
    end

    t_trig tr;

    ezr_cordic u_cx (.i_clk, .i_en(en), .i_angle(s_axis_tdata[15:0]),
                     .o_sin(tr.sx), .o_cos(tr.cx));
    ezr_cordic u_cy (.i_clk, .i_en(en), .i_angle(s_axis_tdata[31:16]),
                     .o_sin(tr.sy), .o_cos(tr.cy));
    ezr_cordic u_cz (.i_clk, .i_en(en), .i_angle(s_axis_tdata[47:32]),
                     .o_sin(tr.sz), .o_cos(tr.cz));

    // stage a: two-factor products
    t_trig r_a;
    t_q r_czsy, r_szsy, r_czcy, r_szcy, r_szcx, r_szsx, r_czcx, r_czsx;
    t_q r_cysx, r_cycx;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a    <= tr;
            r_czsy <= qmul(tr.cz, tr.sy);
            r_szsy <= qmul(tr.sz, tr.sy);
            r_czcy <= qmul(tr.cz, tr.cy);
            r_szcy <= qmul(tr.sz, tr.cy);
            r_szcx <= qmul(tr.sz, tr.cx);
            r_szsx <= qmul(tr.sz, tr.sx);
            r_czcx <= qmul(tr.cz, tr.cx);
            r_czsx <= qmul(tr.cz, tr.sx);
            r_cysx <= qmul(tr.cy, tr.sx);
            r_cycx <= qmul(tr.cy, tr.cx);
        end
    end

    // stage b: triple products and sums; the other entries pass through, m20 negated
    logic signed [QW+1:0] r_s [9];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s[0] <= (QW+2)'(r_czcy);
            r_s[1] <= (QW+2)'(qmul(r_czsy, r_a.sx)) - (QW+2)'(r_szcx);
            r_s[2] <= (QW+2)'(qmul(r_czsy, r_a.cx)) + (QW+2)'(r_szsx);
            r_s[3] <= (QW+2)'(r_szcy);
            r_s[4] <= (QW+2)'(qmul(r_szsy, r_a.sx)) + (QW+2)'(r_czcx);
            r_s[5] <= (QW+2)'(qmul(r_szsy, r_a.cx)) - (QW+2)'(r_czsx);
            r_s[6] <= -(QW+2)'(r_a.sy);
            r_s[7] <= (QW+2)'(r_cysx);
            r_s[8] <= (QW+2)'(r_cycx);
        end
    end

    // stage c: rounding and saturation, then output register
    logic [143:0] r_o;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                r_o[k*OUT_W +: OUT_W] <= to_out(r_s[k]);
            end
        end
    end

    logic [143:0] r_out;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= r_o;
        end
    end
    assign m_axis_tdata = r_out;

`ifndef SYNTHESIS
    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    // input ready whenever the output is empty
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipeline stalled with empty output");
    // an accepted item moves into the pipeline
    a_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_v[0])
        else $error("accepted item lost");
`endif

endmodule
